[rtl/core/mbd_pkg.sv]
// Package for the multi-button debouncer: sizes, register indexes, mode codes
// and the configuration struct shared by the lanes and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mbd_pkg;

  // Number of debounced buttons and width of the pin sample and result mask.
  localparam int BUTTON_COUNT = 16;
  localparam int PIN_W        = 16;
  localparam int TIME_W       = 32;
  localparam int MODE_W       = 2;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME = 2'd1;

  // Debounce mode codes. The unused code behaves as deferred.
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EAGER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEFER = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_DEFER;
  localparam logic [TIME_W-1:0] TIME_RESET = 32'd5000;

  // Configuration seen by every lane.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] dtime;
  } mbd_cfg_t;

endpackage

[rtl/core/mbd_if.sv]
// Channel interfaces of the multi-button debouncer: input samples, debounced
// results and configuration writes. Depends on mbd_pkg.
`timescale 1ns / 1ps

interface mbd_in_if;
  import mbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIN_W-1:0]  pin_levels;
  logic [TIME_W-1:0] time_now;
  modport source (output valid, output pin_levels, output time_now, input ready);
  modport sink   (input valid, input pin_levels, input time_now, output ready);
endinterface

interface mbd_out_if;
  import mbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] pressed_mask;
  modport source (output valid, output pressed_mask, input ready);
  modport sink   (input valid, input pressed_mask, output ready);
endinterface

interface mbd_cfg_if;
  import mbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/mbd_lane.sv]
// One debounce lane: raw level, last change time and debounced level of a
// single button. Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbd_pkg::mbd_cfg_t         cfg,
  input  logic                      load,
  input  logic                      raw,
  input  logic [mbd_pkg::TIME_W-1:0] now,
  output logic                      deb_nxt
);
  import mbd_pkg::*;

  logic              last_r, last_nxt;
  logic              deb_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] elapsed;
  logic              expired;

  // In deferred mode a raw edge restarts the timer before the elapsed check.
  assign base_time = (cfg.mode[1] && (raw != last_r)) ? now : time_r;
  assign elapsed   = now - base_time;
  assign expired   = (raw != deb_r) && (elapsed >= cfg.dtime);

  // Next state for the current mode.
  always_comb begin
    last_nxt = raw;
    deb_nxt  = deb_r;
    time_nxt = time_r;
    case (cfg.mode)
      MODE_NONE: begin
        deb_nxt = raw;
      end
      MODE_EAGER: begin
        if (expired) begin
          deb_nxt  = raw;
          time_nxt = now;
        end
      end
      MODE_DEFER: begin
        time_nxt = base_time;
        if (expired) deb_nxt = raw;
      end
      default: begin
        time_nxt = base_time;
        if (expired) deb_nxt = raw;
      end
    endcase
  end

  // State advances once per accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      deb_r  <= 1'b0;
      time_r <= '0;
    end else if (load) begin
      last_r <= last_nxt;
      deb_r  <= deb_nxt;
      time_r <= time_nxt;
    end
  end

endmodule

[rtl/core/mbd_merge.sv]
// Merge stage: gathers the lane results into the pressed mask and holds it in
// the output register until the transfer completes. Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [mbd_pkg::BUTTON_COUNT-1:0] lane_deb,
  output logic                          busy,
  mbd_out_if.source                     out_ch
);
  import mbd_pkg::*;

  logic             valid_r;
  logic [PIN_W-1:0] mask_r, mask_nxt;

  // Buttons beyond the mask width are dropped; missing ones read as zero.
  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < PIN_W; i++) begin
      if (i < BUTTON_COUNT) mask_nxt[i] = lane_deb[i];
    end
  end

  // The register is free when empty or when its result leaves this cycle.
  assign busy = valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) mask_r <= mask_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.pressed_mask = mask_r;

endmodule

[rtl/core/multi_button_debouncer.sv]
// Multi-button debouncer top level: configuration registers, one lane per
// button and the merge stage. Depends on mbd_pkg, mbd_if, mbd_lane, mbd_merge.
// The pressed mask appears in the cycle after the input transfer.
// Throughput: one sample per cycle unless the output stalls; all lanes update
// at once and the output register accepts a new mask as the old one is taken.
// Reset (synchronous, rst_n low): all lane state cleared, mode deferred,
// debounce time 5000, output empty.
`timescale 1ns / 1ps

module multi_button_debouncer (
  input  logic      clk,
  input  logic      rst_n,
  mbd_in_if.sink    in_ch,
  mbd_out_if.source out_ch,
  mbd_cfg_if.sink   cfg_ch
);
  import mbd_pkg::*;

  mbd_cfg_t              cfg_r;
  logic                  accept;
  logic                  busy;
  logic [BUTTON_COUNT-1:0] lane_deb;

  // Configuration writes; indexes past the list are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_RESET;
      cfg_r.dtime <= TIME_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MODE: cfg_r.mode  <= cfg_ch.data[MODE_W-1:0];
        REG_TIME: cfg_r.dtime <= cfg_ch.data[TIME_W-1:0];
        default:  ;
      endcase
    end
  end

  // Input transfer.
  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  // One lane per button.
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    logic raw;
    if (g < PIN_W) begin : g_pin
      assign raw = in_ch.pin_levels[g];
    end else begin : g_nopin
      assign raw = 1'b0;
    end
    mbd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg_r),
      .load    (accept),
      .raw     (raw),
      .now     (in_ch.time_now),
      .deb_nxt (lane_deb[g])
    );
  end

  // Result merge and output register.
  mbd_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .lane_deb (lane_deb),
    .busy     (busy),
    .out_ch   (out_ch)
  );

endmodule
